>>> rtl/cbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_pkg: circuit breaker table shared definitions
// Table size, command and state codes, register map and the structs
// passed between the breaker table modules.
// ----------------------------------------------------------------------------
package cbt_pkg;

    localparam int SERVICES = 16;
    localparam int IDX_W    = (SERVICES > 1) ? $clog2(SERVICES) : 1;

    localparam int SVC_W    = 4;
    localparam int CMD_W    = 3;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 16;
    localparam int TRIP_W   = 32;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX        = '1;
    localparam logic [CNT_W-1:0] THRESHOLD_RST  = CNT_W'(5);
    localparam logic [TIME_W-1:0] RESET_TIME_RST = TIME_W'(30000);

    typedef enum logic {
        REG_THRESHOLD  = 1'b0,
        REG_RESET_TIME = 1'b1
    } reg_idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER   = 3'd0,
        CMD_UNREGISTER = 3'd1,
        CMD_FAILURE    = 3'd2,
        CMD_SUCCESS    = 3'd3,
        CMD_QUERY      = 3'd4,
        CMD_READ       = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLOSED = 2'd0,
        ST_OPEN   = 2'd1,
        ST_HALF   = 2'd2
    } brk_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  failure_threshold;
        logic [TIME_W-1:0] reset_time_ms;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SVC_W-1:0]  service;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic              available;
        logic [1:0]        breaker_state;
        logic              registered;
        logic [CNT_W-1:0]  failure_count;
        logic [TRIP_W-1:0] trip_total;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/cbt_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_ifs: request and result channels of the breaker table
// Valid/ready channels carrying one command request and one result.
// ----------------------------------------------------------------------------
interface cbt_req_if;
    logic                        valid;
    logic                        ready;
    logic [cbt_pkg::CMD_W-1:0]   command;
    logic [cbt_pkg::SVC_W-1:0]   service;
    logic [cbt_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output command, output service, output now_ms,
                    input ready);
    modport sink   (input valid, input command, input service, input now_ms,
                    output ready);
endinterface

interface cbt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        available;
    logic [1:0]                  breaker_state;
    logic                        registered;
    logic [cbt_pkg::CNT_W-1:0]   failure_count;
    logic [cbt_pkg::TRIP_W-1:0]  trip_total;

    modport source (output valid, output available, output breaker_state,
                    output registered, output failure_count, output trip_total,
                    input ready);
    modport sink   (input valid, input available, input breaker_state,
                    input registered, input failure_count, input trip_total,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/cbt_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_cfg_regs: configuration registers
// APB-style register port holding the failure threshold and reset time.
// ----------------------------------------------------------------------------
module cbt_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cbt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [cbt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [cbt_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output cbt_pkg::cfg_t                          cfg
);

    logic [cbt_pkg::CNT_W-1:0]  threshold_reg;
    logic [cbt_pkg::TIME_W-1:0] reset_time_reg;
    cbt_pkg::reg_idx_t          sel;
    logic                       wr_en;

    assign sel    = cbt_pkg::reg_idx_t'(paddr[cbt_pkg::CFG_ADDR_W-1]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= cbt_pkg::THRESHOLD_RST;
            reset_time_reg <= cbt_pkg::RESET_TIME_RST;
        end
        else if (wr_en)
        begin
            case (sel)
                cbt_pkg::REG_THRESHOLD:  threshold_reg  <= pwdata[cbt_pkg::CNT_W-1:0];
                cbt_pkg::REG_RESET_TIME: reset_time_reg <= pwdata[cbt_pkg::TIME_W-1:0];
                default:                 threshold_reg  <= threshold_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            cbt_pkg::REG_THRESHOLD:  prdata = cbt_pkg::CFG_DATA_W'(threshold_reg);
            cbt_pkg::REG_RESET_TIME: prdata = cbt_pkg::CFG_DATA_W'(reset_time_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.failure_threshold = threshold_reg;
    assign cfg.reset_time_ms     = reset_time_reg;

endmodule
`default_nettype wire

>>> rtl/cbt_entry_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_entry_table: breaker entry storage and update
// Holds the per-service breaker entries and the trip counter, and applies
// one command as a read-modify-write of the addressed entry.
// ----------------------------------------------------------------------------
module cbt_entry_table (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cbt_pkg::cfg_t      cfg,
    input  wire logic               commit,
    input  wire cbt_pkg::item_t     item,
    output cbt_pkg::result_t        result
);

    logic [cbt_pkg::SERVICES-1:0]   valid_reg;
    cbt_pkg::brk_state_t            state_reg [cbt_pkg::SERVICES];
    logic [cbt_pkg::CNT_W-1:0]      count_reg [cbt_pkg::SERVICES];
    logic [cbt_pkg::TIME_W-1:0]     stamp_reg [cbt_pkg::SERVICES];
    logic [cbt_pkg::TRIP_W-1:0]     trips_reg;

    logic [cbt_pkg::IDX_W-1:0]      idx;
    logic                           inrange;
    logic                           hit;
    cbt_pkg::brk_state_t            cur_state;
    logic [cbt_pkg::CNT_W-1:0]      cur_count;
    logic [cbt_pkg::CNT_W-1:0]      inc_count;
    logic [cbt_pkg::TIME_W-1:0]     elapsed;

    logic                           valid_next;
    cbt_pkg::brk_state_t            state_next;
    logic [cbt_pkg::CNT_W-1:0]      count_next;
    logic                           trip;
    logic                           avail;
    logic                           hit_after;
    logic [cbt_pkg::TRIP_W-1:0]     trips_next;

    assign inrange   = 32'(item.service) < 32'(cbt_pkg::SERVICES);
    assign idx       = cbt_pkg::IDX_W'(item.service);
    assign hit       = inrange && valid_reg[idx];
    assign cur_state = state_reg[idx];
    assign cur_count = count_reg[idx];
    assign inc_count = (cur_count == cbt_pkg::CNT_MAX) ? cur_count : cur_count + 1'b1;
    assign elapsed   = item.now_ms - stamp_reg[idx];

    always_comb
    begin
        valid_next = valid_reg[idx];
        state_next = cur_state;
        count_next = cur_count;
        trip       = 1'b0;
        avail      = 1'b0;
        case (cbt_pkg::cmd_t'(item.command))
            cbt_pkg::CMD_REGISTER:
            begin
                valid_next = 1'b1;
                state_next = cbt_pkg::ST_CLOSED;
                count_next = '0;
            end
            cbt_pkg::CMD_UNREGISTER:
            begin
                valid_next = 1'b0;
                state_next = cbt_pkg::ST_CLOSED;
                count_next = '0;
            end
            cbt_pkg::CMD_FAILURE:
            begin
                if (hit && cur_state == cbt_pkg::ST_HALF)
                begin
                    trip = 1'b1;
                end
                else if (hit && cur_state == cbt_pkg::ST_CLOSED)
                begin
                    count_next = inc_count;
                    trip       = inc_count >= cfg.failure_threshold;
                end
            end
            cbt_pkg::CMD_SUCCESS:
            begin
                if (hit && cur_state == cbt_pkg::ST_HALF)
                begin
                    state_next = cbt_pkg::ST_CLOSED;
                    count_next = '0;
                end
                else if (hit && cur_state == cbt_pkg::ST_CLOSED)
                begin
                    count_next = '0;
                end
            end
            cbt_pkg::CMD_QUERY:
            begin
                avail = 1'b1;
                if (hit && cur_state == cbt_pkg::ST_OPEN)
                begin
                    if (elapsed >= cfg.reset_time_ms)
                    begin
                        state_next = cbt_pkg::ST_HALF;
                    end
                    else
                    begin
                        avail = 1'b0;
                    end
                end
            end
            default:
            begin
                avail = 1'b0;
            end
        endcase
        if (trip)
        begin
            state_next = cbt_pkg::ST_OPEN;
        end
    end

    assign trips_next = trip ? trips_reg + 1'b1 : trips_reg;
    assign hit_after  = inrange && valid_next;

    // per-entry state, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            trips_reg <= '0;
            for (int i = 0; i < cbt_pkg::SERVICES; i++)
            begin
                state_reg[i] <= cbt_pkg::ST_CLOSED;
                count_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            trips_reg <= trips_next;
            if (inrange)
            begin
                valid_reg[idx] <= valid_next;
                state_reg[idx] <= state_next;
                count_reg[idx] <= count_next;
            end
        end
    end

    // trip stamps, undefined until first trip
    always_ff @(posedge clk)
    begin
        if (commit && inrange && trip)
        begin
            stamp_reg[idx] <= item.now_ms;
        end
    end

    assign result.available     = avail;
    assign result.breaker_state = hit_after ? state_next : cbt_pkg::ST_CLOSED;
    assign result.registered    = hit_after;
    assign result.failure_count = hit_after ? count_next : '0;
    assign result.trip_total    = trips_next;

endmodule
`default_nettype wire

>>> rtl/circuit_breaker_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circuit_breaker_table: per-service circuit breaker table
// Input register, one read-modify-write of the addressed entry, and a
// result register, with an APB-style configuration port.
// ----------------------------------------------------------------------------
// a request goes from the input register through the entry update into the result register
// throughput: one request per cycle while the result register is not stalled, set by the single entry update path
// the input register takes one more request while a finished result waits
// reset: all entries unregistered and closed, trip count zero,
//        threshold 5, reset time 30000 ms; no clearing pass
module circuit_breaker_table (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    cbt_req_if.sink                                req,
    cbt_rsp_if.source                              rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cbt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [cbt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [cbt_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    cbt_pkg::cfg_t      cfg;
    cbt_pkg::item_t     in_item;
    cbt_pkg::item_t     s1_item_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    cbt_pkg::result_t   result;
    cbt_pkg::result_t   rsp_data_reg;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               advance;
    logic               commit;
    logic               req_fire;

    cbt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;
    assign commit    = s1_valid_reg && advance;

    assign in_item.command = req.command;
    assign in_item.service = req.service;
    assign in_item.now_ms  = req.now_ms;

    assign s1_valid_next  = req_fire || (s1_valid_reg && !advance);
    assign rsp_valid_next = commit || (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (commit)
        begin
            rsp_data_reg <= result;
        end
    end

    cbt_entry_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .commit (commit),
        .item   (s1_item_reg),
        .result (result)
    );

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.available     = rsp_data_reg.available;
    assign rsp.breaker_state = rsp_data_reg.breaker_state;
    assign rsp.registered    = rsp_data_reg.registered;
    assign rsp.failure_count = rsp_data_reg.failure_count;
    assign rsp.trip_total    = rsp_data_reg.trip_total;

    // a stalled request in the input register is neither lost nor changed
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input register lost or changed a stalled request");

    // an empty result register never blocks the request side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid_reg |-> req.ready)
        else $error("request side stalled with empty result register");

    // unknown services always report closed with zero count
    a_unknown_closed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_data_reg.registered |->
            rsp_data_reg.breaker_state == cbt_pkg::ST_CLOSED &&
            rsp_data_reg.failure_count == '0)
        else $error("unregistered service reported breaker state");

endmodule
`default_nettype wire
